// ----- sv/rdeq_pkg.sv -----
package rdeq_pkg;

	// default ring depth
	localparam int unsigned DEF_CAPACITY = 64;

	// operation codes
	typedef enum logic [1:0] {
		OP_PUSH_HEAD = 2'd0,
		OP_PUSH_TAIL = 2'd1,
		OP_POP_HEAD  = 2'd2,
		OP_REVERSE   = 2'd3
	} op_t;

	// request word
	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] item_value;
	} req_word_t;

	// response word
	typedef struct packed {
		logic               success;
		logic signed [31:0] removed_value;
		logic [6:0]         element_count;
	} rsp_word_t;

	// memory port controls
	typedef struct packed {
		logic wr;
		logic rd;
	} mem_ctl_t;

	// per-operation outcome, read data from the registered memory read joins it at the output register
	typedef struct packed {
		logic       success;
		logic       take;
		logic [6:0] element_count;
	} op_res_t;

endpackage

// ----- sv/rdeq_ram.sv -----
module rdeq_ram #(
	parameter int unsigned DEPTH = rdeq_pkg::DEF_CAPACITY,
	parameter int unsigned AW    = $clog2(rdeq_pkg::DEF_CAPACITY)
) (
	input  logic                clk,
	input  rdeq_pkg::mem_ctl_t  ctl,
	input  logic [AW-1:0]       addr,
	input  logic signed [31:0]  wdata,
	output logic signed [31:0]  rdata
);
	import rdeq_pkg::*;

	logic signed [31:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ----- sv/rdeq_ctrl.sv -----
module rdeq_ctrl #(
	parameter int unsigned CAPACITY = rdeq_pkg::DEF_CAPACITY,
	parameter int unsigned PW       = $clog2(rdeq_pkg::DEF_CAPACITY),
	parameter int unsigned CW       = $clog2(rdeq_pkg::DEF_CAPACITY + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  rdeq_pkg::op_t      op,
	output rdeq_pkg::mem_ctl_t ctl,
	output logic [PW-1:0]      addr,
	output rdeq_pkg::op_res_t  res
);
	import rdeq_pkg::*;

	logic [CW-1:0] count_q, count_d;
	logic [PW-1:0] front_q, front_d;
	logic          rev_q, rev_d;

	logic          full, empty;
	logic [PW-1:0] front_inc, front_dec;
	logic [CW-1:0] pos_c;
	logic [PW-1:0] pos;
	logic [PW:0]   fwd_sum, rev_diff;
	logic [PW-1:0] slot;
	mem_ctl_t      ctl_d;

	// ring neighbors of the head
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign front_inc = (front_q == PW'(CAPACITY - 1)) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? PW'(CAPACITY - 1) : front_q - 1'b1;

	// ring slot of the tail end (count) or the last element (count - 1)
	assign pos_c    = (op == OP_PUSH_TAIL) ? count_q : count_q - 1'b1;
	assign pos      = pos_c[PW-1:0];
	assign fwd_sum  = {1'b0, front_q} + {1'b0, pos};
	assign rev_diff = {1'b0, front_q} - {1'b0, pos};

	always_comb begin
		if (rev_q) begin
			slot = rev_diff[PW] ? PW'(rev_diff + (PW+1)'(CAPACITY)) : rev_diff[PW-1:0];
		end else begin
			slot = (fwd_sum >= (PW+1)'(CAPACITY)) ? PW'(fwd_sum - (PW+1)'(CAPACITY))
				: fwd_sum[PW-1:0];
		end
	end

	// next state and memory access for one operation
	always_comb begin
		count_d     = count_q;
		front_d     = front_q;
		rev_d       = rev_q;
		ctl_d       = '0;
		addr        = front_q;
		res.success = 1'b0;
		res.take    = 1'b0;
		case (op)
			OP_PUSH_HEAD: begin
				if (!full) begin
					if (!empty) begin
						front_d = rev_q ? front_inc : front_dec;
					end
					addr        = front_d;
					ctl_d.wr    = 1'b1;
					count_d     = count_q + 1'b1;
					res.success = 1'b1;
				end
			end
			OP_PUSH_TAIL: begin
				if (!full) begin
					addr        = slot;
					ctl_d.wr    = 1'b1;
					count_d     = count_q + 1'b1;
					res.success = 1'b1;
				end
			end
			OP_POP_HEAD: begin
				if (!empty) begin
					addr     = front_q;
					ctl_d.rd = 1'b1;
					count_d  = count_q - 1'b1;
					if (count_q != CW'(1)) begin
						front_d = rev_q ? front_dec : front_inc;
					end
					res.take    = 1'b1;
					res.success = 1'b1;
				end
			end
			OP_REVERSE: begin
				if (!empty) begin
					front_d = slot;
				end
				rev_d       = !rev_q;
				res.success = 1'b1;
			end
			default: begin
				res.success = 1'b0;
			end
		endcase
		res.element_count = 7'(count_d);
		ctl.wr = ctl_d.wr & fire;
		ctl.rd = ctl_d.rd & fire;
	end

	// pointer, count and direction registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			front_q <= '0;
			rev_q   <= 1'b0;
		end else if (fire) begin
			count_q <= count_d;
			front_q <= front_d;
			rev_q   <= rev_d;
		end
	end

	// count never passes the ring depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("count beyond capacity");

	// head pointer stays inside the ring
	a_front_range: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= PW'(CAPACITY - 1))
		else $error("head pointer outside ring");

	// a successful remove drops the count by one
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.take |=> count_q == $past(count_q) - 1'b1)
		else $error("remove did not decrement count");

	// a failed operation leaves the count alone
	a_fail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !res.success |=> $stable(count_q))
		else $error("failed operation changed count");

endmodule

// ----- sv/reversible_double_ended_queue_core.sv -----
// Double-ended queue of signed 32-bit words with a one-step reverse. Each
// request word carries an operation (insert at head, insert at tail, remove
// head, reverse) and a value; each produces exactly one response word with a
// success flag, the removed value (zero unless a remove succeeded) and the
// count held afterward. Entries live in a single-port ring memory of CAPACITY
// words addressed by a head pointer and a direction flag, so reverse only
// moves the pointer and flips the flag. Inserts into a full ring and removes
// from an empty ring fail without changing anything. One request is taken per
// cycle while the response side keeps up. The memory read happens at the edge
// that accepts a request, and the response word is registered once the output
// register is free. While a response word is stalled, one more request is
// taken and then the request side stalls. No clearing pass is needed after
// reset.
module reversible_double_ended_queue_core #(
	parameter int unsigned CAPACITY = rdeq_pkg::DEF_CAPACITY
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  rdeq_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rdeq_pkg::rsp_word_t rsp
);
	import rdeq_pkg::*;

	localparam int unsigned PW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic               fire;
	logic               adv_s1;
	logic               valid_s1;
	op_res_t            res, res_s1;
	mem_ctl_t           ctl;
	logic [PW-1:0]      addr;
	logic signed [31:0] rdata;

	// handshake: stage 1 moves when the output register is free
	assign adv_s1    = valid_s1 && !(rsp_valid && rsp_stall);
	assign req_stall = valid_s1 && !adv_s1;
	assign fire      = req_valid && !req_stall;

	rdeq_ctrl #(
		.CAPACITY (CAPACITY),
		.PW       (PW),
		.CW       (CW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.op     (op_t'(req.operation)),
		.ctl    (ctl),
		.addr   (addr),
		.res    (res)
	);

	rdeq_ram #(
		.DEPTH (CAPACITY),
		.AW    (PW)
	) u_ram (
		.clk   (clk),
		.ctl   (ctl),
		.addr  (addr),
		.wdata (req.item_value),
		.rdata (rdata)
	);

	// stage 1 control, waits for read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1 <= res;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp.success       <= res_s1.success;
			rsp.removed_value <= res_s1.take ? rdata : '0;
			rsp.element_count <= res_s1.element_count;
		end
	end

	// a failed response never carries a value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.success |-> rsp.removed_value == '0)
		else $error("value on failed response");

	// an accepted word always reaches stage 1
	a_fire_s1: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s1)
		else $error("accepted word lost");

endmodule
